>>> rtl/lsfe_pkg.sv
// Shared types, constants and colour/gain functions for the LED strip frame encoder.
package lsfe_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_SHIFT,
        ST_SHIFT_LAST,
        ST_HEAD,
        ST_LOAD,
        ST_SCALE,
        ST_SEND,
        ST_LATCH
    } t_state;

    localparam int PIXEL_W    = 24;
    localparam int CODE_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic [PIXEL_W-1:0]   t_pixel;
    typedef logic [CODE_W-1:0]    t_code;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [3:0]           t_sel;

    localparam t_cfg_idx REG_COLOUR = 2'd0;
    localparam t_cfg_idx REG_BRIGHT = 2'd1;
    localparam t_cfg_idx REG_STEP   = 2'd2;

    localparam t_sel COL_RED     = 4'd1;
    localparam t_sel COL_YELLOW  = 4'd2;
    localparam t_sel COL_GREEN   = 4'd3;
    localparam t_sel COL_CYAN    = 4'd4;
    localparam t_sel COL_BLUE    = 4'd5;
    localparam t_sel COL_MAGENTA = 4'd6;
    localparam t_sel COL_WHITE   = 4'd7;
    localparam t_sel COL_RAINBOW = 4'd8;

    localparam t_code CODE_ONE   = 7'd68;
    localparam t_code CODE_ZERO  = 7'd32;
    localparam t_code CODE_LATCH = 7'd0;

    localparam logic [4:0]  LAST_BIT   = 5'd23;
    localparam logic [4:0]  LAST_BYTE  = 5'd2;
    localparam logic [10:0] WHEEL_SPAN = 11'd765;
    localparam logic [10:0] WHEEL_TWO  = 11'd1530;

    // Q1.16 gain, tan(4.5 deg * level); levels above ten saturate at unity.
    function automatic logic [16:0] gain_of(input t_sel level);
        logic [16:0] g;
        unique case (level)
            4'd0:    g = 17'd0;
            4'd1:    g = 17'd5158;
            4'd2:    g = 17'd10380;
            4'd3:    g = 17'd15734;
            4'd4:    g = 17'd21294;
            4'd5:    g = 17'd27146;
            4'd6:    g = 17'd33392;
            4'd7:    g = 17'd40161;
            4'd8:    g = 17'd47615;
            4'd9:    g = 17'd55973;
            default: g = 17'd65536;
        endcase
        return g;
    endfunction

    // Pixels are packed G, R, B from the top byte down.
    function automatic t_pixel fill_colour(input t_sel sel);
        t_pixel px;
        unique case (sel)
            COL_RED:     px = {8'd0,   8'd255, 8'd0};
            COL_YELLOW:  px = {8'd255, 8'd255, 8'd0};
            COL_GREEN:   px = {8'd255, 8'd0,   8'd0};
            COL_CYAN:    px = {8'd255, 8'd0,   8'd255};
            COL_BLUE:    px = {8'd0,   8'd0,   8'd255};
            COL_MAGENTA: px = {8'd0,   8'd255, 8'd255};
            COL_WHITE:   px = {8'd255, 8'd255, 8'd255};
            default:     px = {8'd20,  8'd20,  8'd20};
        endcase
        return px;
    endfunction

    function automatic t_pixel wheel_colour(input logic [9:0] p);
        logic [9:0] g;
        logic [9:0] r;
        logic [9:0] b;
        if (p < 10'd255) begin
            g = 10'd254 - p;
            r = p + 10'd1;
            b = 10'd0;
        end else if (p < 10'd510) begin
            g = 10'd0;
            r = 10'd509 - p;
            b = p - 10'd254;
        end else begin
            g = p - 10'd509;
            r = 10'd0;
            b = 10'd764 - p;
        end
        return {g[7:0], r[7:0], b[7:0]};
    endfunction

    // The sum stays below three spans, so two conditional subtractions suffice.
    function automatic logic [9:0] wheel_next(input logic [9:0] p, input logic [9:0] step);
        logic [10:0] s;
        s = {1'b0, p} + {1'b0, step};
        if (s >= WHEEL_TWO) begin
            s = s - WHEEL_TWO;
        end else if (s >= WHEEL_SPAN) begin
            s = s - WHEEL_SPAN;
        end
        return s[9:0];
    endfunction

endpackage

>>> rtl/lsfe_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lsfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 27,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/led_strip_frame_encoder.sv
// Top level of the LED strip frame encoder: pixel store, frame advance and bit encoder.
//
// Input channel (i_in_valid / o_in_stall) carries one request: i_mode 0 advances the
// frame contents, i_mode 1 encodes pixel i_pixel_index. One request is worked at a time.
// A frame advance with a solid colour writes every pixel, one per cycle; a rainbow
// advance shifts the strip by one pixel through the RAM port and then writes the new
// head pixel. It produces no output.
// An encode request reads the pixel, scales G, R and B through one shared multiplier
// and then sends 24 duty codes, one per cycle while i_out_stall is low, on the output
// channel (o_out_valid / i_out_stall), MSB first. The last pixel of the strip adds a
// latch code of 0. o_last_code marks the final code of each request. The next request
// is taken only after the pixel read, the scaling and the last code are done.
// The output register holds a code while i_out_stall is high and the sequencer waits.
// Indexes at or beyond the strip length are accepted and dropped.
// Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set colour select,
// brightness level and step size; they are expected only while the block is idle.
// Reset: pixels read as zero until the first frame advance, wheel position zero,
// colour select 7, brightness 1, step size 4. No clearing pass is needed.
module led_strip_frame_encoder
    import lsfe_pkg::*;
#(
    parameter int STRIP_LENGTH = 27
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [0:0]            i_mode,
    input  logic [4:0]            i_pixel_index,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CODE_W-1:0]     o_duty_code,
    output logic [0:0]            o_last_code,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (STRIP_LENGTH > 1) ? $clog2(STRIP_LENGTH) : 1;
    localparam logic [8:0]    LEN9        = 9'(STRIP_LENGTH);
    localparam logic [AW-1:0] LAST_ADDR   = AW'(STRIP_LENGTH - 1);
    localparam logic [AW-1:0] SHIFT_START = AW'((STRIP_LENGTH > 1) ? STRIP_LENGTH - 2 : 0);

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_pend, n_pend;
    logic [4:0]    r_sub, n_sub;
    t_pixel        r_pixel, n_pixel;
    t_pixel        r_word, n_word;
    logic [16:0]   r_gain, n_gain;
    logic          r_last_px, n_last_px;
    logic          r_mem_init, n_mem_init;
    logic [9:0]    r_wheel, n_wheel;
    t_sel          r_colour;
    t_sel          r_bright;
    logic [9:0]    r_step;
    logic          r_out_valid, n_out_valid;
    t_code         r_duty, n_duty;
    logic          r_last, n_last;

    logic          w_accept;
    logic          w_in_range;
    logic [8:0]    w_idx9;
    logic          w_free;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    t_pixel        w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    t_pixel        w_rd_data;
    t_pixel        w_rd_pixel;
    logic [24:0]   w_prod;

    lsfe_ram #(
        .WIDTH(PIXEL_W),
        .DEPTH(STRIP_LENGTH)
    ) u_pixel_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_idx9     = {4'd0, i_pixel_index};
    assign w_in_range = (w_idx9 < LEN9);
    assign w_free     = !r_out_valid || !i_out_stall;
    // Entries never written since reset hold garbage; they read as zero until the
    // first frame advance has rewritten the whole store.
    assign w_rd_pixel = r_mem_init ? w_rd_data : '0;
    assign w_prod     = 25'(r_pixel[23:16]) * 25'(r_gain);

    assign o_out_valid = r_out_valid;
    assign o_duty_code = r_duty;
    assign o_last_code = r_last;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_mode == 1'b0) begin
                        if (r_colour == COL_RAINBOW) begin
                            n_state = (STRIP_LENGTH > 1) ? ST_SHIFT : ST_HEAD;
                        end else begin
                            n_state = ST_FILL;
                        end
                    end else if (w_in_range) begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_FILL: begin
                if (r_cnt == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT: begin
                if (r_cnt == '0) begin
                    n_state = ST_SHIFT_LAST;
                end
            end
            ST_SHIFT_LAST: n_state = ST_HEAD;
            ST_HEAD:       n_state = ST_IDLE;
            ST_LOAD:       n_state = ST_SCALE;
            ST_SCALE: begin
                if (r_sub == LAST_BYTE) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (w_free && (r_sub == LAST_BIT)) begin
                    n_state = r_last_px ? ST_LATCH : ST_IDLE;
                end
            end
            ST_LATCH: begin
                if (w_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_sub       = r_sub;
        n_pixel     = r_pixel;
        n_word      = r_word;
        n_gain      = r_gain;
        n_last_px   = r_last_px;
        n_mem_init  = r_mem_init;
        n_wheel     = r_wheel;
        n_out_valid = r_out_valid && i_out_stall;
        n_duty      = r_duty;
        n_last      = r_last;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_cnt;
        w_wr_data   = fill_colour(r_colour);
        w_rd_en     = 1'b0;
        w_rd_addr   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt  = (r_colour == COL_RAINBOW) ? SHIFT_START : '0;
                n_pend = 1'b0;
                n_sub  = '0;
                n_gain = gain_of(r_bright);
                n_last_px = (w_idx9 == LEN9 - 9'd1);
                if (w_accept && (i_mode == 1'b1) && w_in_range) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_idx9[AW-1:0];
                end
            end
            ST_FILL: begin
                w_wr_en = 1'b1;
                n_cnt   = r_cnt + AW'(1);
                if (r_cnt == LAST_ADDR) begin
                    n_mem_init = 1'b1;
                end
            end
            ST_SHIFT: begin
                // Walk downward: read entry k while the entry read last cycle lands at k+2.
                w_rd_en   = 1'b1;
                w_wr_en   = r_pend;
                w_wr_addr = r_cnt + AW'(2);
                w_wr_data = w_rd_pixel;
                n_pend    = 1'b1;
                n_cnt     = r_cnt - AW'(1);
            end
            ST_SHIFT_LAST: begin
                w_wr_en   = 1'b1;
                w_wr_addr = AW'(1);
                w_wr_data = w_rd_pixel;
            end
            ST_HEAD: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = '0;
                w_wr_data  = wheel_colour(r_wheel);
                n_wheel    = wheel_next(r_wheel, r_step);
                n_mem_init = 1'b1;
            end
            ST_LOAD: begin
                n_pixel = w_rd_pixel;
            end
            ST_SCALE: begin
                n_word  = {r_word[15:0], w_prod[23:16]};
                n_pixel = {r_pixel[15:0], 8'd0};
                n_sub   = (r_sub == LAST_BYTE) ? 5'd0 : r_sub + 5'd1;
            end
            ST_SEND: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_duty      = r_word[23] ? CODE_ONE : CODE_ZERO;
                    n_last      = (r_sub == LAST_BIT) && !r_last_px;
                    n_word      = {r_word[22:0], 1'b0};
                    n_sub       = r_sub + 5'd1;
                end
            end
            ST_LATCH: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_duty      = CODE_LATCH;
                    n_last      = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mem_init  <= 1'b0;
            r_wheel     <= '0;
            r_out_valid <= 1'b0;
            r_colour    <= COL_WHITE;
            r_bright    <= 4'd1;
            r_step      <= 10'd4;
        end else begin
            r_state     <= n_state;
            r_mem_init  <= n_mem_init;
            r_wheel     <= n_wheel;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_COLOUR: r_colour <= i_cfg_data[3:0];
                    REG_BRIGHT: r_bright <= i_cfg_data[3:0];
                    REG_STEP:   r_step   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt     <= n_cnt;
        r_pend    <= n_pend;
        r_sub     <= n_sub;
        r_pixel   <= n_pixel;
        r_word    <= n_word;
        r_gain    <= n_gain;
        r_last_px <= n_last_px;
        r_duty    <= n_duty;
        r_last    <= n_last;
    end

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_wr_en)
        else $error("pixel RAM written while idle");

    a_wheel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wheel < WHEEL_SPAN[9:0])
        else $error("wheel position out of range");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duty_code == CODE_ONE || o_duty_code == CODE_ZERO
                         || o_duty_code == CODE_LATCH))
        else $error("illegal duty code");

    a_latch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_duty_code == CODE_LATCH) |-> o_last_code)
        else $error("latch code not marked last");

    a_encode_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_mode == 1'b1 && w_in_range) |=> (r_state == ST_LOAD))
        else $error("encode request did not start a pixel read");

endmodule
